### hdl/sctg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sctg_pkg;
    // configuration register indexes
    localparam logic [2:0] REG_RADIUS     = 3'd0;
    localparam logic [2:0] REG_SLICE_CNT  = 3'd1;
    localparam logic [2:0] REG_STACK_CNT  = 3'd2;
    localparam logic [2:0] REG_SLICE_STEP = 3'd3;
    localparam logic [2:0] REG_STACK_STEP = 3'd4;

    // one vertex word on the result side
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               triangle_sel;
        logic [1:0]         corner;
        logic               index_error;
        logic               last;
    } t_vertex;

    // quarter-wave sine entry, Q1.15, from the Taylor series in Q30
    function automatic logic [15:0] qsine_entry(input int unsigned k, input int unsigned quarter);
        logic [63:0] x, x2, term, sum, q;
        x = (64'(k) * 64'd1686629713) / 64'(quarter);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        return q[15:0];
    endfunction
endpackage
`default_nettype wire

### hdl/sctg_angle.sv
`timescale 1ns / 1ps
`default_nettype none
// Stage A: index check and phase products; Stage B: table lookups.
module sctg_angle #(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_DIVISIONS   = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_adv,
    input  wire         i_valid,
    input  wire  [9:0]  i_stack_index,
    input  wire  [9:0]  i_slice_index,
    input  wire  [10:0] i_slice_count,
    input  wire  [10:0] i_stack_count,
    input  wire  [15:0] i_slice_step,
    input  wire  [15:0] i_stack_step,
    output logic        o_valid,
    output logic        o_err,
    output logic signed [15:0] o_st0,
    output logic signed [15:0] o_ct0,
    output logic signed [15:0] o_st1,
    output logic signed [15:0] o_ct1,
    output logic signed [15:0] o_sr0,
    output logic signed [15:0] o_cr0,
    output logic signed [15:0] o_sr1,
    output logic signed [15:0] o_cr1
);
    import sctg_pkg::*;
    localparam int TB = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (TB - 2);
    localparam int MD_W = $clog2(MAX_DIVISIONS + 1);
    localparam int LW = (MD_W > 11) ? MD_W : 11;

    logic [15:0] qtab [QUARTER + 1];
    always_comb begin
        for (int k = 0; k <= QUARTER; k++) qtab[k] = qsine_entry(k, QUARTER);
    end

    function automatic logic signed [15:0] sine_idx(input logic [TB-1:0] idx);
        logic [1:0] quad;
        logic [TB-3:0] r;
        logic [TB-2:0] rr;
        logic [15:0] v;
        quad = idx[TB-1:TB-2];
        r = idx[TB-3:0];
        rr = (TB-1)'(QUARTER) - {1'b0, r};
        v = (quad[0]) ? qtab[rr] : qtab[{1'b0, r}];
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction

    // phase to table index: truncate when the phase is wider, else shift left
    function automatic logic [TB-1:0] tidx(input logic [PHASE_BITS-1:0] ph);
        return TB'({ph, {TB{1'b0}}} >> PHASE_BITS);
    endfunction

    // stage A
    logic r_va, r_err;
    logic [PHASE_BITS-1:0] r_th0, r_th1, r_rh0, r_rh1;
    logic [LW-1:0] lim_st, lim_sl;
    logic [PHASE_BITS-1:0] n_th0, n_th1, n_rh0, n_rh1;
    always_comb begin
        lim_st = (LW'(i_stack_count) < LW'(MAX_DIVISIONS)) ? LW'(i_stack_count)
                                                            : LW'(MAX_DIVISIONS);
        lim_sl = (LW'(i_slice_count) < LW'(MAX_DIVISIONS)) ? LW'(i_slice_count)
                                                            : LW'(MAX_DIVISIONS);
        n_rh0 = PHASE_BITS'(27'(i_stack_index) * 27'(i_stack_step));
        n_rh1 = PHASE_BITS'(27'({1'b0, i_stack_index} + 11'd1) * 27'(i_stack_step));
        n_th0 = PHASE_BITS'(27'(i_slice_index) * 27'(i_slice_step));
        n_th1 = (({1'b0, i_slice_index} + 11'd1) == i_slice_count) ? '0 :
                PHASE_BITS'(27'({1'b0, i_slice_index} + 11'd1) * 27'(i_slice_step));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
        end
        if (i_adv) begin
            r_err <= (LW'(i_stack_index) >= lim_st) || (LW'(i_slice_index) >= lim_sl);
            r_th0 <= n_th0; r_th1 <= n_th1; r_rh0 <= n_rh0; r_rh1 <= n_rh1;
        end
    end

    // stage B: lookups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r_va;
        end
        if (i_adv) begin
            o_err <= r_err;
            o_st0 <= -sine_idx(tidx(r_th0));
            o_ct0 <= sine_idx(tidx(r_th0) + TB'(QUARTER));
            o_st1 <= -sine_idx(tidx(r_th1));
            o_ct1 <= sine_idx(tidx(r_th1) + TB'(QUARTER));
            o_sr0 <= sine_idx(tidx(r_rh0));
            o_cr0 <= sine_idx(tidx(r_rh0) + TB'(QUARTER));
            o_sr1 <= sine_idx(tidx(r_rh1));
            o_cr1 <= sine_idx(tidx(r_rh1) + TB'(QUARTER));
        end
    end
endmodule
`default_nettype wire

### hdl/sctg_vertex.sv
`timescale 1ns / 1ps
`default_nettype none
// Stage C: direction products; stage D: radius scaling and rounding.
module sctg_vertex (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_adv,
    input  wire         i_valid,
    input  wire         i_err,
    input  wire  [15:0] i_radius,
    input  wire  signed [15:0] i_st0, i_ct0, i_st1, i_ct1,
    input  wire  signed [15:0] i_sr0, i_cr0, i_sr1, i_cr1,
    output logic        o_valid,
    output logic        o_err,
    // vertices P1..P4 as x,y,z positions; directions of P1, P2
    output logic signed [23:0] o_px [4],
    output logic signed [23:0] o_py [4],
    output logic signed [23:0] o_pz [4],
    output logic signed [15:0] o_nx [2],
    output logic signed [15:0] o_ny [2],
    output logic signed [15:0] o_nz [2]
);
    import sctg_pkg::*;
    logic r_vc, r_ec;
    logic signed [31:0] r_ax [4], r_ay [4];
    logic signed [15:0] r_cz [4];
    logic signed [15:0] st [4], ct [4], sr [4], cr [4];
    always_comb begin
        // P1 (th0,rh0) P2 (th0,rh1) P3 (th1,rh0) P4 (th1,rh1)
        st[0] = i_st0; ct[0] = i_ct0; sr[0] = i_sr0; cr[0] = i_cr0;
        st[1] = i_st0; ct[1] = i_ct0; sr[1] = i_sr1; cr[1] = i_cr1;
        st[2] = i_st1; ct[2] = i_ct1; sr[2] = i_sr0; cr[2] = i_cr0;
        st[3] = i_st1; ct[3] = i_ct1; sr[3] = i_sr1; cr[3] = i_cr1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (i_adv) r_vc <= i_valid;
        if (i_adv) begin
            r_ec <= i_err;
            for (int v = 0; v < 4; v++) begin
                r_ax[v] <= st[v] * sr[v];
                r_ay[v] <= ct[v] * sr[v];
                r_cz[v] <= cr[v];
            end
        end
    end

    logic signed [48:0] mx [4], my [4];
    logic signed [32:0] mz [4];
    logic signed [31:0] nrm_x [4], nrm_y [4];
    logic signed [16:0] rad;
    always_comb begin
        rad = $signed({1'b0, i_radius});
        for (int v = 0; v < 4; v++) begin
            mx[v] = (49'(r_ax[v]) * 49'(rad) + 49'sd536870912) >>> 30;
            my[v] = (49'(r_ay[v]) * 49'(rad) + 49'sd536870912) >>> 30;
            mz[v] = (33'(r_cz[v]) * 33'(rad) + 33'sd16384) >>> 15;
            nrm_x[v] = (r_ax[v] + 32'sd16384) >>> 15;
            nrm_y[v] = (r_ay[v] + 32'sd16384) >>> 15;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_adv) o_valid <= r_vc;
        if (i_adv) begin
            o_err <= r_ec;
            for (int v = 0; v < 4; v++) begin
                o_px[v] <= mx[v][23:0];
                o_py[v] <= my[v][23:0];
                o_pz[v] <= mz[v][23:0];
            end
            for (int v = 0; v < 2; v++) begin
                o_nx[v] <= nrm_x[v][15:0];
                o_ny[v] <= nrm_y[v][15:0];
                o_nz[v] <= r_cz[v];
            end
        end
    end
endmodule
`default_nettype wire

### hdl/sctg_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// Holds one finished cell and sends its six vertex words, or one error word, with an output register.
module sctg_serializer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_take,
    input  wire         i_err,
    input  wire  signed [23:0] i_px [4],
    input  wire  signed [23:0] i_py [4],
    input  wire  signed [23:0] i_pz [4],
    input  wire  signed [15:0] i_nx [2],
    input  wire  signed [15:0] i_ny [2],
    input  wire  signed [15:0] i_nz [2],
    output logic        o_valid,
    input  wire         i_ready,
    output sctg_pkg::t_vertex o_word
);
    import sctg_pkg::*;
    logic r_full, r_err;
    logic [2:0] r_cnt;
    logic signed [23:0] r_px [4], r_py [4], r_pz [4];
    logic signed [15:0] r_nx [2], r_ny [2], r_nz [2];
    logic out_free, emit, done;
    logic [1:0] pv;
    logic nv;
    t_vertex n_word;

    assign out_free = !o_valid || i_ready;
    assign emit = r_full && out_free;
    assign done = emit && (r_err || r_cnt == 3'd5);
    assign o_take = !r_full || done;

    // vertex order P1 P2 P3 / P2 P4 P3
    always_comb begin
        case (r_cnt)
            3'd0: pv = 2'd0;
            3'd1: pv = 2'd1;
            3'd2: pv = 2'd2;
            3'd3: pv = 2'd1;
            3'd4: pv = 2'd3;
            default: pv = 2'd2;
        endcase
        nv = (r_cnt >= 3'd3);
        n_word = '0;
        if (r_err) begin
            n_word.index_error = 1'b1;
            n_word.last = 1'b1;
        end else begin
            n_word.pos_x = r_px[pv];
            n_word.pos_y = r_py[pv];
            n_word.pos_z = r_pz[pv];
            n_word.norm_x = r_nx[nv];
            n_word.norm_y = r_ny[nv];
            n_word.norm_z = r_nz[nv];
            n_word.triangle_sel = nv;
            n_word.corner = nv ? 2'(r_cnt - 3'd3) : r_cnt[1:0];
            n_word.last = (r_cnt == 3'd5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_full <= i_valid;
                r_cnt <= '0;
            end else if (emit) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
        if (emit) o_word <= n_word;
        if (o_take) begin
            r_err <= i_err;
            r_px <= i_px; r_py <= i_py; r_pz <= i_pz;
            r_nx <= i_nx; r_ny <= i_ny; r_nz <= i_nz;
        end
    end
endmodule
`default_nettype wire

### hdl/sphere_cell_triangle_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sphere cell triangle generator: each accepted (stack, slice) word yields six
// vertex words (two triangles, P1 P2 P3 then P2 P4 P3), or one word with
// index_error set when an index is out of range. The result port carries a
// single vertex word at a time, so the serializer takes the next cell only as it
// sends the last word of the current one. Four pipeline stages (phase, lookup, direction
// product, radius scale) advance together and hold while the output side stalls.
module sphere_cell_triangle_generator_core #(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_DIVISIONS   = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [9:0]  i_stack_index,
    input  wire  [9:0]  i_slice_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic signed [23:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic        o_triangle_sel,
    output logic [1:0]  o_corner,
    output logic        o_index_error,
    output logic        o_last
);
    import sctg_pkg::*;
    logic [15:0] r_radius, r_slice_step, r_stack_step;
    logic [10:0] r_slice_cnt, r_stack_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_slice_cnt <= 11'd16;
            r_stack_cnt <= 11'd16;
            r_slice_step <= 16'd4096;
            r_stack_step <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIUS:     r_radius <= i_cfg_data;
                REG_SLICE_CNT:  r_slice_cnt <= i_cfg_data[10:0];
                REG_STACK_CNT:  r_stack_cnt <= i_cfg_data[10:0];
                REG_SLICE_STEP: r_slice_step <= i_cfg_data;
                REG_STACK_STEP: r_stack_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances when the last stage can hand off or is empty
    logic adv, take, vb, vd, eb, ed;
    logic signed [15:0] st0, ct0, st1, ct1, sr0, cr0, sr1, cr1;
    logic signed [23:0] px [4], py [4], pz [4];
    logic signed [15:0] nx [2], ny [2], nz [2];
    t_vertex word;
    assign adv = take || !vd;
    assign o_ready = adv;

    sctg_angle #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS),
                 .MAX_DIVISIONS(MAX_DIVISIONS)) u_angle (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid,
        .i_stack_index, .i_slice_index,
        .i_slice_count(r_slice_cnt), .i_stack_count(r_stack_cnt),
        .i_slice_step(r_slice_step), .i_stack_step(r_stack_step),
        .o_valid(vb), .o_err(eb),
        .o_st0(st0), .o_ct0(ct0), .o_st1(st1), .o_ct1(ct1),
        .o_sr0(sr0), .o_cr0(cr0), .o_sr1(sr1), .o_cr1(cr1)
    );

    sctg_vertex u_vertex (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid(vb), .i_err(eb), .i_radius(r_radius),
        .i_st0(st0), .i_ct0(ct0), .i_st1(st1), .i_ct1(ct1),
        .i_sr0(sr0), .i_cr0(cr0), .i_sr1(sr1), .i_cr1(cr1),
        .o_valid(vd), .o_err(ed),
        .o_px(px), .o_py(py), .o_pz(pz), .o_nx(nx), .o_ny(ny), .o_nz(nz)
    );

    sctg_serializer u_ser (
        .i_clk, .i_rst_n, .i_valid(vd), .o_take(take), .i_err(ed),
        .i_px(px), .i_py(py), .i_pz(pz), .i_nx(nx), .i_ny(ny), .i_nz(nz),
        .o_valid, .i_ready, .o_word(word)
    );

    assign o_pos_x = word.pos_x;
    assign o_pos_y = word.pos_y;
    assign o_pos_z = word.pos_z;
    assign o_norm_x = word.norm_x;
    assign o_norm_y = word.norm_y;
    assign o_norm_z = word.norm_z;
    assign o_triangle_sel = word.triangle_sel;
    assign o_corner = word.corner;
    assign o_index_error = word.index_error;
    assign o_last = word.last;
endmodule
`default_nettype wire

### hdl/sctg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sctg_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire [1:0]  o_corner,
    input wire        o_triangle_sel,
    input wire        o_index_error,
    input wire        o_last
);
    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_corner) && $stable(o_last))
        else $error("result word changed while stalled");
    // corner never reaches three
    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_corner != 2'd3)
        else $error("bad corner");
    // errors stand alone and close the item
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> o_last && o_corner == 2'd0 && !o_triangle_sel)
        else $error("error word malformed");
    // last is the third corner of the second triangle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_index_error |-> o_triangle_sel && o_corner == 2'd2)
        else $error("last on wrong vertex");
endmodule
bind sphere_cell_triangle_generator_core sctg_checker u_sctg_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_corner, .o_triangle_sel,
    .o_index_error, .o_last
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import sctg_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int CYCLE_LIMIT = 400000;

    // Holds the register copy, the sine table and the vertex words still owed.
    class cell_scoreboard;
        t_vertex     vertex_q[$];
        int unsigned mismatches;
        longint      radius, slice_cnt, stack_cnt, slice_step, stack_step;
        longint      qsin[257];

        function new();
            longint unsigned x, x2, term, acc, q;
            for (int k = 0; k <= 256; k++) begin
                x = (longint'(k) * 64'd1686629713) / 256;
                x2 = (x * x) >> 30;
                term = x;
                acc = x;
                for (int n = 1; n <= 9; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) acc = acc - term;
                    else acc = acc + term;
                end
                q = (acc + 64'd16384) >> 15;
                qsin[k] = (q > 32767) ? 32767 : q;
            end
            radius = 256; slice_cnt = 16; stack_cnt = 16;
            slice_step = 4096; stack_step = 2048;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_RADIUS:     radius = val;
                REG_SLICE_CNT:  slice_cnt = val[10:0];
                REG_STACK_CNT:  stack_cnt = val[10:0];
                REG_SLICE_STEP: slice_step = val;
                REG_STACK_STEP: stack_step = val;
                default: ;
            endcase
        endfunction

        function longint sine_at(int unsigned idx);
            int unsigned r, quad;
            idx = idx & 1023;
            quad = idx >> 8;
            r = idx & 255;
            case (quad)
                0: return qsin[r];
                1: return qsin[256 - r];
                2: return -qsin[r];
                default: return -qsin[256 - r];
            endcase
        endfunction

        // round half up by an arithmetic shift
        function longint rshift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // one point of the sphere: position and unit direction
        function t_vertex sphere_point(logic [15:0] theta, logic [15:0] rho);
            t_vertex v;
            longint st, ct, sr, cr;
            st = -sine_at(theta >> 6);
            ct = sine_at((theta >> 6) + 256);
            sr = sine_at(rho >> 6);
            cr = sine_at((rho >> 6) + 256);
            v = '0;
            v.norm_x = 16'(rshift(st * sr, 15));
            v.norm_y = 16'(rshift(ct * sr, 15));
            v.norm_z = 16'(cr);
            v.pos_x = 24'(rshift(st * sr * radius, 30));
            v.pos_y = 24'(rshift(ct * sr * radius, 30));
            v.pos_z = 24'(rshift(cr * radius, 15));
            return v;
        endfunction

        function t_vertex corner_word(t_vertex pt, t_vertex nv, bit tsel, int c, bit lst);
            t_vertex w;
            w = pt;
            w.norm_x = nv.norm_x; w.norm_y = nv.norm_y; w.norm_z = nv.norm_z;
            w.triangle_sel = tsel; w.corner = 2'(c); w.index_error = 0; w.last = lst;
            return w;
        endfunction

        // append one expected word
        function void queue_word(t_vertex w);
            vertex_q = {vertex_q, w};
        endfunction

        // accepted cell request: queue its six vertex words or the error word
        function void note_cell(logic [9:0] si, logic [9:0] sl);
            t_vertex p1, p2, p3, p4, e;
            longint lim_st, lim_sl;
            logic [15:0] rho0, rho1, th0, th1;
            lim_st = (stack_cnt < 1024) ? stack_cnt : 1024;
            lim_sl = (slice_cnt < 1024) ? slice_cnt : 1024;
            if (si >= lim_st || sl >= lim_sl) begin
                e = '0;
                e.index_error = 1;
                e.last = 1;
                queue_word(e);
                return;
            end
            rho0 = 16'(longint'(si) * stack_step);
            rho1 = 16'(longint'(si + 1) * stack_step);
            th0 = 16'(longint'(sl) * slice_step);
            th1 = (longint'(sl) + 1 == slice_cnt) ? 16'd0 : 16'(longint'(sl + 1) * slice_step);
            p1 = sphere_point(th0, rho0);
            p2 = sphere_point(th0, rho1);
            p3 = sphere_point(th1, rho0);
            p4 = sphere_point(th1, rho1);
            queue_word(corner_word(p1, p1, 0, 0, 0));
            queue_word(corner_word(p2, p1, 0, 1, 0));
            queue_word(corner_word(p3, p1, 0, 2, 0));
            queue_word(corner_word(p2, p2, 1, 0, 0));
            queue_word(corner_word(p4, p2, 1, 1, 0));
            queue_word(corner_word(p3, p2, 1, 2, 1));
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex exp;
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex word %h", got);
                return;
            end
            exp = vertex_q.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("vertex mismatch: exp pos %h %h %h nrm %h %h %h t%0d c%0d e%0d l%0d",
                             exp.pos_x, exp.pos_y, exp.pos_z, exp.norm_x, exp.norm_y,
                             exp.norm_z, exp.triangle_sel, exp.corner, exp.index_error,
                             exp.last, "\n                 got pos %h %h %h nrm %h %h %h",
                             got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y,
                             got.norm_z, " t%0d c%0d e%0d l%0d", got.triangle_sel,
                             got.corner, got.index_error, got.last);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_valid = 0, i_ready = 0;
    logic [9:0] i_stack_index = '0, i_slice_index = '0;
    logic o_ready, o_valid;
    t_vertex out_word;
    bit send_idle = 1, recv_idle = 1;
    int cycles = 0;
    cell_scoreboard sb;

    sphere_cell_triangle_generator_core dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_ready, .i_stack_index, .i_slice_index,
        .o_valid, .i_ready,
        .o_pos_x(out_word.pos_x), .o_pos_y(out_word.pos_y), .o_pos_z(out_word.pos_z),
        .o_norm_x(out_word.norm_x), .o_norm_y(out_word.norm_y),
        .o_norm_z(out_word.norm_z), .o_triangle_sel(out_word.triangle_sel),
        .o_corner(out_word.corner), .o_index_error(out_word.index_error),
        .o_last(out_word.last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side monitor and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) sb.check_vertex(out_word);
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls before each word while recv_idle is set
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = recv_idle ? $urandom_range(0, 16) : 0;
            if (n > 0) begin
                i_ready <= 0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_cell(logic [9:0] si, logic [9:0] sl);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_stack_index <= si;
        i_slice_index <= sl;
        do @(posedge i_clk); while (!o_ready);
        sb.note_cell(si, sl);
    endtask

    // mostly in-range cells, some anywhere in the field range
    task automatic send_random(int count);
        int unsigned lst, lsl;
        for (int k = 0; k < count; k++) begin
            send_idle = (k % 40) >= 10;
            recv_idle = (k % 30) < 20;
            lst = (sb.stack_cnt < 1024) ? 32'(sb.stack_cnt) : 32'd1024;
            lsl = (sb.slice_cnt < 1024) ? 32'(sb.slice_cnt) : 32'd1024;
            if ($urandom_range(0, 99) < 85 && lst > 0 && lsl > 0)
                send_cell(10'($urandom_range(0, lst - 1)), 10'($urandom_range(0, lsl - 1)));
            else
                send_cell(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.vertex_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: corners, wrap slice, out of range
        send_cell(0, 0); send_cell(15, 15); send_cell(15, 0); send_cell(0, 15);
        send_cell(16, 0); send_cell(0, 16); send_cell(1023, 1023); send_cell(7, 3);
        send_random(40);
        drain();

        // largest counts and radius, fine steps
        write_cfg(REG_RADIUS, 16'hFFFF);
        write_cfg(REG_SLICE_CNT, 16'd1024);
        write_cfg(REG_STACK_CNT, 16'd1024);
        write_cfg(REG_SLICE_STEP, 16'd64);
        write_cfg(REG_STACK_STEP, 16'd32);
        send_cell(1023, 1023); send_cell(1023, 0); send_cell(512, 1023); send_cell(0, 0);
        send_random(40);
        drain();

        // smallest counts, zero radius, largest steps; unused index ignored
        write_cfg(REG_RADIUS, 16'd0);
        write_cfg(REG_SLICE_CNT, 16'd3);
        write_cfg(REG_STACK_CNT, 16'd2);
        write_cfg(REG_SLICE_STEP, 16'hFFFF);
        write_cfg(REG_STACK_STEP, 16'd32768);
        write_cfg(REG_UNUSED, 16'h1234);
        send_cell(1, 2); send_cell(0, 0); send_cell(2, 0); send_cell(0, 3);
        drain();
        write_cfg(REG_RADIUS, 16'd1);
        send_cell(1, 2); send_cell(1, 1);
        drain();

        // random settings, counts above the limit and zero
        write_cfg(REG_RADIUS, 16'($urandom_range(0, 65535)));
        write_cfg(REG_SLICE_CNT, 16'd2047);
        write_cfg(REG_STACK_CNT, 16'($urandom_range(2, 1024)));
        write_cfg(REG_SLICE_STEP, 16'($urandom_range(0, 65535)));
        write_cfg(REG_STACK_STEP, 16'($urandom_range(0, 32768)));
        send_random(40);
        drain();
        write_cfg(REG_SLICE_CNT, 16'd0);
        send_cell(0, 0); send_cell(5, 5);
        drain();
        write_cfg(REG_SLICE_CNT, 16'($urandom_range(3, 64)));
        write_cfg(REG_STACK_CNT, 16'($urandom_range(2, 64)));
        write_cfg(REG_RADIUS, 16'($urandom_range(0, 65535)));
        send_random(40);
        drain();

        if (sb.mismatches == 0 && sb.vertex_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### sphere_cell_triangle_generator_core.f
hdl/sctg_pkg.sv
hdl/sctg_angle.sv
hdl/sctg_vertex.sv
hdl/sctg_serializer.sv
hdl/sphere_cell_triangle_generator_core.sv
hdl/sctg_checker.sv
tb/tb.sv
